/* hw/rtl/dps_pkg.sv */
`default_nettype none
package dps_pkg;

    localparam int MAX_WORDS    = 256;
    localparam int MAX_WORD_LEN = 10;
    localparam int MAX_SEQ_LEN  = 1048576;

    localparam int CMD_W   = 2;
    localparam int WIDX_W  = 8;
    localparam int CPOS_W  = 4;
    localparam int CHAR_W  = 8;
    localparam int WC_W    = 9;
    localparam int OUT_W   = 21;

    localparam int WORD_AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CNT_W   = $clog2(MAX_WORDS + 1);
    localparam int SEQ_W   = $clog2(MAX_SEQ_LEN + 1);

    localparam int QDEPTH  = 2;
    localparam int Q_AW    = 1;
    localparam int Q_CW    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_SEQ   = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } back_state_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [WIDX_W-1:0] widx;
        logic [CPOS_W-1:0] cpos;
        logic [CHAR_W-1:0] cval;
    } req_t;

    typedef logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] char_row_t;

    // A word of length L matches when the newest L characters, read oldest
    // first, equal the word and the prefix before them is reachable.
    function automatic logic dps_word_hit(
        input char_row_t               row,
        input char_row_t               win,
        input logic [MAX_WORD_LEN:0]   reach
    );
        logic [MAX_WORD_LEN-1:0] ended;
        logic [MAX_WORD_LEN-1:0] eq;
        logic                    hit;
        ended = '0;
        eq    = '1;
        hit   = 1'b0;
        for (int k = 0; k < MAX_WORD_LEN; k++)
        begin
            if (k == 0)
                ended[k] = (row[k] == '0);
            else
                ended[k] = ended[k-1] || (row[k] == '0);
        end
        for (int l = 1; l <= MAX_WORD_LEN; l++)
        begin
            for (int k = 0; k < l; k++)
            begin
                if (row[k] != win[l-1-k])
                    eq[l-1] = 1'b0;
            end
        end
        for (int l = 1; l <= MAX_WORD_LEN; l++)
        begin
            // Length is exactly l: no zero among the first l, and a zero or
            // the end of the row right after.
            if (!ended[l-1] && ((l == MAX_WORD_LEN) || ended[l % MAX_WORD_LEN])
                && reach[l-1] && eq[l-1])
                hit = 1'b1;
        end
        return hit;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/dictionary_prefix_segmenter.sv */
// Longest segmentable prefix finder. Load the dictionary one character per
// request (command 1), set word_count, send a start request (command 0) and
// then stream sequence characters (command 2); every request returns one
// result. Start, load and no-op requests need no dictionary scan. A sequence
// character is checked against the dictionary words in order, because the
// dictionary RAM delivers one word per cycle, up to min(word_count, 256)
// words, stopping early at the first match. A two-entry queue in front keeps
// accepting requests until it is full while a character is being scanned or
// a result waits on out_stall. Change word_count only while the block is idle.
`default_nettype none
module dictionary_prefix_segmenter
    import dps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              word_count_wr_en,
    input  wire logic [WC_W-1:0]   word_count_wr_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [CMD_W-1:0]  command,
    input  wire logic [WIDX_W-1:0] word_index,
    input  wire logic [CPOS_W-1:0] char_position,
    input  wire logic [CHAR_W-1:0] char_value,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [OUT_W-1:0]       longest_prefix,
    output logic                   now_reachable,
    output logic                   length_saturated
);

    logic q_valid;
    logic q_take;
    req_t q_req;

    dps_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .word_index   (word_index),
        .char_position(char_position),
        .char_value   (char_value),
        .q_valid      (q_valid),
        .q_req        (q_req),
        .q_take       (q_take)
    );

    dps_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .word_count_wr_en  (word_count_wr_en),
        .word_count_wr_data(word_count_wr_data),
        .q_valid           (q_valid),
        .q_req             (q_req),
        .q_take            (q_take),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .longest_prefix    (longest_prefix),
        .now_reachable     (now_reachable),
        .length_saturated  (length_saturated)
    );

endmodule
`default_nettype wire

/* hw/rtl/dps_ram.sv */
`default_nettype none
module dps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* hw/rtl/dps_front.sv */
`default_nettype none
module dps_front
    import dps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [CMD_W-1:0]  command,
    input  wire logic [WIDX_W-1:0] word_index,
    input  wire logic [CPOS_W-1:0] char_position,
    input  wire logic [CHAR_W-1:0] char_value,
    output logic                   q_valid,
    output req_t                   q_req,
    input  wire logic              q_take
);

    req_t            fifo_reg [QDEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_CW-1:0] count_reg;
    logic            push;
    req_t            in_req;

    always_comb
    begin
        in_req.cmd  = cmd_t'(command);
        in_req.widx = word_index;
        in_req.cpos = char_position;
        in_req.cval = char_value;
    end

    assign in_stall = (count_reg == Q_CW'(QDEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_req    = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= in_req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (q_take)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !q_take)
                count_reg <= count_reg + 1'b1;
            else if (!push && q_take)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/dps_back.sv */
`default_nettype none
module dps_back
    import dps_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             word_count_wr_en,
    input  wire logic [WC_W-1:0]  word_count_wr_data,
    input  wire logic             q_valid,
    input  req_t                  q_req,
    output logic                  q_take,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [OUT_W-1:0]      longest_prefix,
    output logic                  now_reachable,
    output logic                  length_saturated
);

    back_state_t             state_reg, state_next;
    char_row_t               win_reg, win_next;
    logic [MAX_WORD_LEN:0]   reach_reg, reach_next;
    logic [SEQ_W-1:0]        pos_reg, pos_next;
    logic [SEQ_W-1:0]        best_reg, best_next;
    logic                    sat_reg, sat_next;
    logic [WC_W-1:0]         wc_reg;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]        out_len_reg, out_len_next;
    logic                    out_hit_reg, out_hit_next;
    logic                    out_sat_reg, out_sat_next;

    char_row_t               row_data;
    logic [WORD_AW-1:0]      raddr;
    logic                    load_we;
    logic [CNT_W-1:0]        limit;
    logic                    hit;
    logic                    fin;
    logic                    fin_hit;
    logic [CNT_W-1:0]        cnt_inc;

    always_comb
    begin
        if (32'(wc_reg) > MAX_WORDS)
            limit = CNT_W'(MAX_WORDS);
        else
            limit = CNT_W'(wc_reg);
    end

    assign load_we = q_take && (q_req.cmd == CMD_LOAD) && (32'(q_req.widx) < MAX_WORDS);
    assign cnt_inc = cnt_reg + 1'b1;
    assign hit     = dps_word_hit(row_data, win_reg, reach_reg);

    // One RAM lane per character position; all lanes read the same word.
    for (genvar i = 0; i < MAX_WORD_LEN; i++)
    begin : g_lane
        dps_ram #(
            .WIDTH(CHAR_W),
            .DEPTH(MAX_WORDS)
        ) u_ram (
            .clk  (clk),
            .we   (load_we && (32'(q_req.cpos) == i)),
            .waddr(WORD_AW'(q_req.widx)),
            .wdata(q_req.cval),
            .raddr(raddr),
            .rdata(row_data[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        win_next       = win_reg;
        reach_next     = reach_reg;
        pos_next       = pos_reg;
        best_next      = best_reg;
        sat_next       = sat_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_len_next   = out_len_reg;
        out_hit_next   = out_hit_reg;
        out_sat_next   = out_sat_reg;
        q_take         = 1'b0;
        fin            = 1'b0;
        fin_hit        = 1'b0;
        raddr          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                q_take = q_valid && (!out_valid_reg || !out_stall);
                if (q_take)
                begin
                    case (q_req.cmd)
                        CMD_START:
                        begin
                            win_next       = '0;
                            reach_next     = (MAX_WORD_LEN + 1)'(1);
                            pos_next       = '0;
                            best_next      = '0;
                            sat_next       = 1'b0;
                            out_valid_next = 1'b1;
                            out_len_next   = '0;
                            out_hit_next   = 1'b0;
                            out_sat_next   = 1'b0;
                        end
                        CMD_SEQ:
                        begin
                            for (int k = MAX_WORD_LEN - 1; k > 0; k--)
                                win_next[k] = win_reg[k-1];
                            win_next[0] = q_req.cval;
                            if (limit == '0)
                                fin = 1'b1;
                            else
                            begin
                                cnt_next   = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_len_next   = OUT_W'(best_reg);
                            out_hit_next   = 1'b0;
                            out_sat_next   = sat_reg;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Read data now holds the word at cnt_reg; fetch the next one.
                raddr = cnt_inc[WORD_AW-1:0];
                if (hit || (cnt_inc == limit))
                begin
                    fin        = 1'b1;
                    fin_hit    = hit;
                    state_next = ST_IDLE;
                end
                else
                    cnt_next = cnt_inc;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin)
        begin
            reach_next = {reach_reg[MAX_WORD_LEN-1:0], fin_hit};
            if (pos_reg < SEQ_W'(MAX_SEQ_LEN))
                pos_next = pos_reg + 1'b1;
            else
                sat_next = 1'b1;
            if (fin_hit)
                best_next = pos_next;
            out_valid_next = 1'b1;
            out_len_next   = OUT_W'(best_next);
            out_hit_next   = fin_hit;
            out_sat_next   = sat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_reg       <= '0;
            reach_reg     <= (MAX_WORD_LEN + 1)'(1);
            pos_reg       <= '0;
            best_reg      <= '0;
            sat_reg       <= 1'b0;
            wc_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            win_reg       <= win_next;
            reach_reg     <= reach_next;
            pos_reg       <= pos_next;
            best_reg      <= best_next;
            sat_reg       <= sat_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (word_count_wr_en)
                wc_reg <= word_count_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        out_len_reg <= out_len_next;
        out_hit_reg <= out_hit_next;
        out_sat_reg <= out_sat_next;
    end

    assign out_valid        = out_valid_reg;
    assign longest_prefix   = out_len_reg;
    assign now_reachable    = out_hit_reg;
    assign length_saturated = out_sat_reg;

endmodule
`default_nettype wire

/* hw/rtl/dps_checker.sv */
`default_nettype none
module dps_checker
    import dps_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              word_count_wr_en,
    input wire logic [WC_W-1:0]   word_count_wr_data,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic [CMD_W-1:0]  command,
    input wire logic [WIDX_W-1:0] word_index,
    input wire logic [CPOS_W-1:0] char_position,
    input wire logic [CHAR_W-1:0] char_value,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [OUT_W-1:0]  longest_prefix,
    input wire logic              now_reachable,
    input wire logic              length_saturated
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(longest_prefix)
            && $stable(now_reachable) && $stable(length_saturated))
        else $error("stalled result changed");

    // A reachable position always carries a nonzero prefix length.
    a_hit_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && now_reachable |-> longest_prefix != '0)
        else $error("reachable result with zero length");

    // The reported length never passes the sequence limit.
    a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(longest_prefix) <= MAX_SEQ_LEN)
        else $error("prefix length beyond limit");

endmodule

bind dictionary_prefix_segmenter dps_checker u_dps_checker (.*);
`default_nettype wire

/* test/dictionary_prefix_segmenter_tb.sv */
`timescale 1ns / 1ps
module dictionary_prefix_segmenter_tb;
    import dps_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;

    typedef struct packed {
        logic [OUT_W-1:0] prefix_len;
        logic             reachable;
        logic             saturated;
    } seg_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              word_count_wr_en = 1'b0;
    logic [WC_W-1:0]   word_count_wr_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [CMD_W-1:0]  command = CMD_NOP;
    logic [WIDX_W-1:0] word_index = '0;
    logic [CPOS_W-1:0] char_position = '0;
    logic [CHAR_W-1:0] char_value = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [OUT_W-1:0]  longest_prefix;
    logic              now_reachable;
    logic              length_saturated;

    dictionary_prefix_segmenter u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .word_count_wr_en   (word_count_wr_en),
        .word_count_wr_data (word_count_wr_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .command            (command),
        .word_index         (word_index),
        .char_position      (char_position),
        .char_value         (char_value),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .longest_prefix     (longest_prefix),
        .now_reachable      (now_reachable),
        .length_saturated   (length_saturated)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Segmenter state as the testbench tracks it.
    logic [CHAR_W-1:0]     dict_mem [MAX_WORDS][MAX_WORD_LEN];
    bit                    dict_set [MAX_WORDS][MAX_WORD_LEN];
    logic [CHAR_W-1:0]     recent_chars [MAX_WORD_LEN];
    logic [MAX_WORD_LEN:0] reach_bits = (MAX_WORD_LEN + 1)'(1);
    int unsigned           seq_pos = 0;
    int unsigned           best_len = 0;
    bit                    sat_flag = 0;
    int unsigned           dict_words = 0;

    seg_result_t pending_results[$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    bit          gaps_on = 1;
    bit          stalls_on = 1;
    int          random_items = 0;

    function automatic int word_length(int w);
        int n;
        n = 0;
        while (n < MAX_WORD_LEN && dict_mem[w][n] != 0)
            n++;
        return n;
    endfunction

    // A word can be scanned only if every character up to its end was loaded.
    function automatic bit word_loaded(int w);
        for (int k = 0; k < MAX_WORD_LEN; k++)
        begin
            if (!dict_set[w][k])
                return 0;
            if (dict_mem[w][k] == 0)
                return 1;
        end
        return 1;
    endfunction

    function automatic int loaded_words();
        int n;
        n = 0;
        while (n < MAX_WORDS && word_loaded(n))
            n++;
        return n;
    endfunction

    function automatic void clear_sequence();
        foreach (recent_chars[k])
            recent_chars[k] = '0;
        reach_bits = (MAX_WORD_LEN + 1)'(1);
        seq_pos = 0;
        best_len = 0;
        sat_flag = 0;
    endfunction

    function automatic seg_result_t segment_step(cmd_t c, logic [WIDX_W-1:0] wi,
                                                 logic [CPOS_W-1:0] cp,
                                                 logic [CHAR_W-1:0] cv);
        seg_result_t r;
        logic [MAX_WORD_LEN:0] prev_reach;
        bit hit;
        int lim;
        int len;
        bit same;
        hit = 0;
        case (c)
            CMD_START: clear_sequence();
            CMD_LOAD:
            begin
                if (wi < MAX_WORDS && cp < MAX_WORD_LEN)
                begin
                    dict_mem[wi][cp] = cv;
                    dict_set[wi][cp] = 1;
                end
            end
            CMD_SEQ:
            begin
                prev_reach = reach_bits;
                for (int k = MAX_WORD_LEN - 1; k > 0; k--)
                    recent_chars[k] = recent_chars[k-1];
                recent_chars[0] = cv;
                lim = (dict_words < MAX_WORDS) ? dict_words : MAX_WORDS;
                for (int w = 0; w < lim && !hit; w++)
                begin
                    len = word_length(w);
                    if (len > 0 && prev_reach[len-1])
                    begin
                        same = 1;
                        for (int k = 0; k < len; k++)
                            if (dict_mem[w][k] != recent_chars[len-1-k])
                                same = 0;
                        hit = same;
                    end
                end
                reach_bits = {prev_reach[MAX_WORD_LEN-1:0], hit};
                if (seq_pos < MAX_SEQ_LEN)
                    seq_pos++;
                else
                    sat_flag = 1;
                if (hit)
                    best_len = seq_pos;
            end
            default: ;
        endcase
        r.prefix_len = best_len[OUT_W-1:0];
        r.reachable  = hit;
        r.saturated  = sat_flag;
        return r;
    endfunction

    // Sends one request, with bursts and gaps when enabled, and records its result.
    task automatic send_req(cmd_t c, logic [WIDX_W-1:0] wi, logic [CPOS_W-1:0] cp,
                            logic [CHAR_W-1:0] cv);
        if (gaps_on && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        in_valid      <= 1'b1;
        command       <= c;
        word_index    <= wi;
        char_position <= cp;
        char_value    <= cv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(segment_step(c, wi, cp, cv));
        if (burst_left > 0)
            burst_left--;
    endtask

    // Waits with the input idle until every pending result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_word_count(int unsigned v);
        drain();
        word_count_wr_en   <= 1'b1;
        word_count_wr_data <= v[WC_W-1:0];
        @(posedge clk);
        word_count_wr_en <= 1'b0;
        dict_words = v;
    endtask

    task automatic load_word(int w, string s, bit terminate);
        for (int k = 0; k < s.len(); k++)
            send_req(CMD_LOAD, w[WIDX_W-1:0], k[CPOS_W-1:0], s[k]);
        if (terminate && s.len() < MAX_WORD_LEN)
            send_req(CMD_LOAD, w[WIDX_W-1:0], CPOS_W'(s.len()), 8'd0);
    endtask

    task automatic send_text(string s);
        for (int k = 0; k < s.len(); k++)
            send_req(CMD_SEQ, '0, '0, s[k]);
    endtask

    task automatic test_directed();
        load_word(0, "a", 1);
        load_word(1, "ab", 1);
        load_word(2, "abc", 1);
        send_req(CMD_LOAD, 8'd3, 4'd0, 8'd0);
        load_word(4, "abcdefghij", 0);
        send_req(CMD_LOAD, 8'd5, 4'd0, 8'hFF);
        send_req(CMD_LOAD, 8'd5, 4'd1, 8'd0);
        // Positions past the word length must leave the dictionary alone.
        send_req(CMD_LOAD, 8'd0, 4'd10, 8'h61);
        send_req(CMD_LOAD, 8'd0, 4'd15, 8'hFF);
        send_req(CMD_LOAD, 8'd255, 4'd0, 8'd0);
        set_word_count(6);
        send_req(CMD_START, '0, '0, '0);
        send_text("abcab");
        send_req(CMD_NOP, 8'hFF, 4'hF, 8'hFF);
        send_req(CMD_SEQ, '0, '0, 8'hFF);
        send_req(CMD_SEQ, '0, '0, 8'd0);
        send_text("a");
        send_req(CMD_START, '0, '0, '0);
        send_text("abcdefghija");
        send_req(CMD_SEQ, '0, '0, 8'hFF);
        set_word_count(0);
        send_req(CMD_START, '0, '0, '0);
        send_text("aa");
    endtask

    // Gives every word a random spelling, mostly short, so any word count is legal.
    task automatic test_full_dictionary();
        int len;
        string s;
        for (int w = 0; w < MAX_WORDS; w++)
        begin
            len = ($urandom_range(0, 15) == 0) ? MAX_WORD_LEN : $urandom_range(0, 3);
            s = "";
            for (int k = 0; k < len; k++)
                s = {s, string'(CHAR_W'(8'h61 + $urandom_range(0, 3)))};
            if (len == 0)
                send_req(CMD_LOAD, w[WIDX_W-1:0], 4'd0, 8'd0);
            else
                load_word(w, s, 1);
        end
        set_word_count(MAX_WORDS);
        send_req(CMD_START, '0, '0, '0);
        send_text("abcdabcdab");
        set_word_count(511);
        send_text("dcba");
    endtask

    task automatic test_random();
        int n;
        int pick;
        int w;
        int lim;
        int cp;
        logic [CHAR_W-1:0] cv;
        logic [CHAR_W-1:0] spelled[$];
        logic [CHAR_W-1:0] saved_char;
        bit saved_set;
        while (random_items < 200)
        begin
            lim = loaded_words();
            pick = $urandom_range(0, 9);
            if (pick == 0)
                set_word_count((lim < MAX_WORDS) ? lim : 256);
            else if (pick == 1)
                set_word_count(0);
            else
                set_word_count($urandom_range(1, (lim < 12) ? lim : 12));
            n = (dict_words > 32) ? $urandom_range(5, 15) : $urandom_range(30, 120);
            if ($urandom_range(0, 1))
                send_req(CMD_START, WIDX_W'($urandom), CPOS_W'($urandom),
                         CHAR_W'($urandom));
            spelled.delete();
            repeat (n)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    if (spelled.size() == 0 && dict_words > 0)
                    begin
                        w = $urandom_range(0, ((dict_words < MAX_WORDS) ? dict_words : MAX_WORDS) - 1);
                        for (int k = 0; k < word_length(w); k++)
                            spelled.push_back(dict_mem[w][k]);
                    end
                    if (spelled.size() != 0 && $urandom_range(0, 19) != 0)
                        cv = spelled.pop_front();
                    else
                        cv = ($urandom_range(0, 3) == 0) ? CHAR_W'($urandom)
                                                         : CHAR_W'(8'h61 + $urandom_range(0, 3));
                    send_req(CMD_SEQ, WIDX_W'($urandom), CPOS_W'($urandom), cv);
                end
                else if (pick < 88)
                begin
                    w = $urandom_range(0, MAX_WORDS - 1);
                    cp = $urandom_range(0, 15);
                    cv = ($urandom_range(0, 2) == 0) ? CHAR_W'($urandom)
                                                     : CHAR_W'(8'h61 + $urandom_range(0, 3));
                    // A load that would leave a word without its end becomes a zero.
                    if (cp < MAX_WORD_LEN)
                    begin
                        saved_char = dict_mem[w][cp];
                        saved_set = dict_set[w][cp];
                        dict_mem[w][cp] = cv;
                        dict_set[w][cp] = 1;
                        if (!word_loaded(w))
                            cv = 8'd0;
                        dict_mem[w][cp] = saved_char;
                        dict_set[w][cp] = saved_set;
                    end
                    send_req(CMD_LOAD, w[WIDX_W-1:0], cp[CPOS_W-1:0], cv);
                end
                else if (pick < 94)
                    send_req(CMD_NOP, WIDX_W'($urandom), CPOS_W'($urandom),
                             CHAR_W'($urandom));
                else
                begin
                    send_req(CMD_START, WIDX_W'($urandom), CPOS_W'($urandom),
                             CHAR_W'($urandom));
                    spelled.delete();
                end
                random_items++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        seg_result_t want;
        if (out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: prefix %0d reach %0d sat %0d",
                             longest_prefix, now_reachable, length_saturated);
            end
            else
            begin
                want = pending_results.pop_front();
                if (longest_prefix !== want.prefix_len || now_reachable !== want.reachable
                    || length_saturated !== want.saturated)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected prefix %0d reach %0d sat %0d, got %0d %0d %0d",
                                 want.prefix_len, want.reachable, want.saturated,
                                 longest_prefix, now_reachable, length_saturated);
                end
            end
        end
    end

    // The receiver switches between free flow, random stalls and long stalls.
    always @(posedge clk)
    begin
        int stall_mode;
        int mode_left;
        if (mode_left <= 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        if (!stalls_on || stall_mode == 0)
            out_stall <= 1'b0;
        else if (stall_mode == 1)
            out_stall <= 1'($urandom_range(0, 1));
        else
            out_stall <= ($urandom_range(0, 7) != 0);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        clear_sequence();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_dictionary();
        test_random();
        drain();
        repeat (300) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
